FILE: hw/rtl/camera_pose_view_matrix_unit_assert.svh
// Assertion macros for the camera pose view matrix unit checker.
// Used by the checker file only; no other dependencies.
`ifndef CAMERA_POSE_VIEW_MATRIX_UNIT_ASSERT_SVH
`define CAMERA_POSE_VIEW_MATRIX_UNIT_ASSERT_SVH

// Checked every clock outside reset.
`define CPVM_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("cpvm assertion failed");

// Checked every clock, reset included.
`define CPVM_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("cpvm assertion failed during reset");

`endif

FILE: hw/rtl/cpvm_pkg.sv
// Shared types, constants and fixed-point helpers of the camera pose unit.
// No dependencies.
`timescale 1ns / 1ps

package cpvm_pkg;

   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 18;
   localparam int MUL_P_W = 52;
   localparam int MUL_CNT_W = 5;
   localparam logic [MUL_CNT_W-1:0] MUL_LAST = 5'd17;

   localparam logic [1:0] CSR_IDX_MOVE = 2'd0;
   localparam logic [1:0] CSR_IDX_TURN = 2'd1;
   localparam logic [15:0] MOVE_STEP_RESET = 16'd6554;
   localparam logic [11:0] TURN_STEP_RESET = 12'd64;

   localparam logic [16:0] POLY_A = 17'd102944;
   localparam logic [16:0] POLY_B = 17'd42048;
   localparam logic [33:0] POLY_C = 34'd4640;
   localparam logic signed [15:0] QUARTER = 16'sd16384;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOK_YAW,
      ST_LOOK_PITCH,
      ST_TRIG_X2,
      ST_TRIG_CX,
      ST_TRIG_XT,
      ST_TRIG_S,
      ST_MOVE_EX,
      ST_MOVE_EZ,
      ST_ROT10,
      ST_ROT12,
      ST_ROT20,
      ST_ROT22,
      ST_DOT,
      ST_EMIT
   } state_type;

   // Quarter-wave argument with 16 fraction bits.
   function automatic logic [16:0] trig_x(input logic [15:0] ang);
      logic [14:0] r;
      r = ang[14] ? (15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
      return {r, 2'b00};
   endfunction

   // Round half up by 14 bits.
   function automatic logic signed [51:0] round_trig(input logic signed [51:0] v);
      return (v + 52'sd8192) >>> 14;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      if (v > 34'sd2147483647) return 32'sh7fffffff;
      if (v < -34'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

endpackage

FILE: hw/rtl/cpvm_serial_mul.sv
// Bit-serial signed multiplier, one multiplier bit per clock.
// Depends on cpvm_pkg.
`timescale 1ns / 1ps

module cpvm_serial_mul (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [cpvm_pkg::MUL_A_W-1:0] op_a,
   input  logic signed [cpvm_pkg::MUL_B_W-1:0] op_b,
   output logic                                done,
   output logic signed [cpvm_pkg::MUL_P_W-1:0] product
);

   logic signed [cpvm_pkg::MUL_A_W:0]   hi_ff, hi_in, addend, sum;
   logic [cpvm_pkg::MUL_B_W-1:0]        lo_ff, lo_in;
   logic signed [cpvm_pkg::MUL_A_W-1:0] a_ff, a_in;
   logic [cpvm_pkg::MUL_CNT_W-1:0]      cnt_ff, cnt_in;
   logic                                busy_ff, busy_in, done_ff, done_in;
   logic [cpvm_pkg::MUL_A_W+cpvm_pkg::MUL_B_W:0] full;

   always_comb begin
      hi_in = hi_ff;
      lo_in = lo_ff;
      a_in = a_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      addend = '0;
      sum = hi_ff;
      if (start) begin
         hi_in = '0;
         lo_in = op_b;
         a_in = op_a;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // multiplier MSB carries negative weight
         if (lo_ff[0])
            addend = (cnt_ff == cpvm_pkg::MUL_LAST) ? -{a_ff[cpvm_pkg::MUL_A_W-1], a_ff}
                                                    : {a_ff[cpvm_pkg::MUL_A_W-1], a_ff};
         sum = hi_ff + addend;
         hi_in = {sum[cpvm_pkg::MUL_A_W], sum[cpvm_pkg::MUL_A_W:1]};
         lo_in = {sum[0], lo_ff[cpvm_pkg::MUL_B_W-1:1]};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == cpvm_pkg::MUL_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      hi_ff <= hi_in;
      lo_ff <= lo_in;
      a_ff <= a_in;
   end

   assign full = {hi_ff, lo_ff};
   assign done = done_ff;
   assign product = full[cpvm_pkg::MUL_P_W-1:0];

endmodule

FILE: hw/rtl/camera_pose_view_matrix_unit.sv
// Top level of the camera pose view matrix unit: sequencer, pose state,
// output register. Depends on cpvm_pkg and cpvm_serial_mul.
//
//   port group | direction | handshake          | carries
//   req_       | in        | req_valid/stall    | event type, mouse deltas, keys
//   rsp_       | out       | rsp_valid/stall    | one view matrix row
//   csr_       | in        | csr_valid/ready    | move_step (0), turn_step (1)
//
// Every product goes through one shared bit-serial multiplier.
// Look request: 2 products. Frame request: 31 products, then three rows
// through the output register.
// Reset is synchronous; no request is taken while one is in work; rsp_stall
// holds the current row, and the next request is taken once row 2 is loaded.
`timescale 1ns / 1ps

module camera_pose_view_matrix_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   input  logic signed [11:0] req_mouse_dx,
   input  logic signed [11:0] req_mouse_dy,
   input  logic [5:0]         req_key_bits,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_row_index,
   output logic signed [15:0] rsp_rot_a,
   output logic signed [15:0] rsp_rot_b,
   output logic signed [15:0] rsp_rot_c,
   output logic signed [33:0] rsp_trans,
   output logic               rsp_last_row,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   cpvm_pkg::state_type state_ff, state_in;

   logic [15:0] move_step_ff, move_step_in;
   logic [11:0] turn_step_ff, turn_step_in;
   logic [15:0] yaw_ff, yaw_in;
   logic signed [15:0] pitch_ff, pitch_in;
   logic signed [31:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in, pos_z_ff, pos_z_in;
   logic signed [11:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [5:0] keys_ff, keys_in;
   logic [16:0] x_ff, x_in, x2_ff, x2_in, t_ff, t_in;
   logic neg_ff, neg_in;
   logic [1:0] sel_ff, sel_in;
   logic signed [15:0] sy_ff, sy_in, cy_ff, cy_in, sp_ff, sp_in, cp_ff, cp_in;
   logic signed [15:0] r10_ff, r10_in, r12_ff, r12_in, r20_ff, r20_in, r22_ff, r22_in;
   logic signed [17:0] ex_ff, ex_in;
   logic signed [51:0] acc_ff, acc_in;
   logic signed [33:0] trans_ff, trans_in;
   logic [1:0] k_ff, k_in, m_ff, m_in;
   logic issued_ff, issued_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_row_ff, rsp_row_in;
   logic signed [15:0] rsp_a_ff, rsp_a_in, rsp_b_ff, rsp_b_in, rsp_c_ff, rsp_c_in;
   logic signed [33:0] rsp_t_ff, rsp_t_in;
   logic rsp_last_ff, rsp_last_in;

   logic mul_start, mul_done;
   logic signed [33:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [51:0] prod, rnd, dot_sum, dot_rnd;
   logic [17:0] s_raw;
   logic [15:0] s_rnd;
   logic [14:0] s_mag;
   logic signed [15:0] s_val;
   logic [15:0] next_ang;
   logic signed [25:0] p_wide;
   logic signed [17:0] ez_now;
   logic signed [33:0] px, pz, py;
   logic signed [15:0] rot_km, row_a, row_b, row_c;
   logic signed [31:0] pos_m;
   logic out_free;

   cpvm_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (prod)
   );

   assign rnd = cpvm_pkg::round_trig(prod);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      unique case (k_ff)
         2'd0: begin
            row_a = cy_ff;
            row_b = 16'sd0;
            row_c = -sy_ff;
         end
         2'd1: begin
            row_a = r10_ff;
            row_b = cp_ff;
            row_c = r12_ff;
         end
         default: begin
            row_a = r20_ff;
            row_b = -sp_ff;
            row_c = r22_ff;
         end
      endcase
      case (m_ff)
         2'd0: begin
            rot_km = row_a;
            pos_m = pos_x_ff;
         end
         2'd1: begin
            rot_km = row_b;
            pos_m = pos_y_ff;
         end
         default: begin
            rot_km = row_c;
            pos_m = pos_z_ff;
         end
      endcase
   end

   always_comb begin
      unique case (sel_ff)
         2'd0: next_ang = yaw_ff + 16'd16384;
         2'd1: next_ang = pitch_ff;
         default: next_ang = pitch_ff + 16'sd16384;
      endcase
      s_raw = prod[33:16];
      s_rnd = 16'((s_raw + 18'd2) >> 2);
      s_mag = (s_rnd > 16'd16384) ? 15'd16384 : s_rnd[14:0];
      s_val = neg_ff ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
      p_wide = {{10{pitch_ff[15]}}, pitch_ff} + prod[25:0];
      ez_now = -rnd[17:0];
      dot_sum = (m_ff == 2'd0) ? prod : acc_ff + prod;
      dot_rnd = cpvm_pkg::round_trig(dot_sum);
      px = {{2{pos_x_ff[31]}}, pos_x_ff};
      pz = {{2{pos_z_ff[31]}}, pos_z_ff};
      py = {{2{pos_y_ff[31]}}, pos_y_ff};
      if (keys_ff[0] && !keys_ff[1]) begin
         px = px + ex_ff;
         pz = pz + ez_now;
      end else if (keys_ff[1] && !keys_ff[0]) begin
         px = px - ex_ff;
         pz = pz - ez_now;
      end
      if (keys_ff[2] && !keys_ff[3]) begin
         px = px + ez_now;
         pz = pz - ex_ff;
      end else if (keys_ff[3] && !keys_ff[2]) begin
         px = px - ez_now;
         pz = pz + ex_ff;
      end
      if (keys_ff[4] && !keys_ff[5])
         py = py + $signed({18'd0, move_step_ff});
      else if (keys_ff[5] && !keys_ff[4])
         py = py - $signed({18'd0, move_step_ff});
   end

   always_comb begin
      state_in = state_ff;
      move_step_in = move_step_ff;
      turn_step_in = turn_step_ff;
      yaw_in = yaw_ff;
      pitch_in = pitch_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      pos_z_in = pos_z_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      keys_in = keys_ff;
      x_in = x_ff;
      x2_in = x2_ff;
      t_in = t_ff;
      neg_in = neg_ff;
      sel_in = sel_ff;
      sy_in = sy_ff;
      cy_in = cy_ff;
      sp_in = sp_ff;
      cp_in = cp_ff;
      r10_in = r10_ff;
      r12_in = r12_ff;
      r20_in = r20_ff;
      r22_in = r22_ff;
      ex_in = ex_ff;
      acc_in = acc_ff;
      trans_in = trans_ff;
      k_in = k_ff;
      m_in = m_ff;
      issued_in = issued_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_row_in = rsp_row_ff;
      rsp_a_in = rsp_a_ff;
      rsp_b_in = rsp_b_ff;
      rsp_c_in = rsp_c_ff;
      rsp_t_in = rsp_t_ff;
      rsp_last_in = rsp_last_ff;
      mul_start = 1'b0;
      mul_a = '0;
      mul_b = '0;
      req_stall = (state_ff != cpvm_pkg::ST_IDLE);

      if (csr_valid) begin
         if (csr_index == cpvm_pkg::CSR_IDX_MOVE)
            move_step_in = csr_wdata;
         else if (csr_index == cpvm_pkg::CSR_IDX_TURN)
            turn_step_in = csr_wdata[11:0];
      end

      unique case (state_ff)
         cpvm_pkg::ST_LOOK_YAW, cpvm_pkg::ST_LOOK_PITCH: begin
            mul_a = {22'd0, turn_step_ff};
            mul_b = (state_ff == cpvm_pkg::ST_LOOK_YAW) ? {{6{dx_ff[11]}}, dx_ff}
                                                      : {{6{dy_ff[11]}}, dy_ff};
         end
         cpvm_pkg::ST_TRIG_X2: begin
            mul_a = {17'd0, x_ff};
            mul_b = {1'b0, x_ff};
         end
         cpvm_pkg::ST_TRIG_CX: begin
            mul_a = cpvm_pkg::POLY_C;
            mul_b = {1'b0, x2_ff};
         end
         cpvm_pkg::ST_TRIG_XT: begin
            mul_a = {17'd0, t_ff};
            mul_b = {1'b0, x2_ff};
         end
         cpvm_pkg::ST_TRIG_S: begin
            mul_a = {17'd0, t_ff};
            mul_b = {1'b0, x_ff};
         end
         cpvm_pkg::ST_MOVE_EX, cpvm_pkg::ST_MOVE_EZ: begin
            mul_a = {18'd0, move_step_ff};
            mul_b = (state_ff == cpvm_pkg::ST_MOVE_EX) ? {{2{sy_ff[15]}}, sy_ff}
                                                     : {{2{cy_ff[15]}}, cy_ff};
         end
         cpvm_pkg::ST_ROT10, cpvm_pkg::ST_ROT12: begin
            mul_a = {{18{sp_ff[15]}}, sp_ff};
            mul_b = (state_ff == cpvm_pkg::ST_ROT10) ? {{2{sy_ff[15]}}, sy_ff}
                                                   : {{2{cy_ff[15]}}, cy_ff};
         end
         cpvm_pkg::ST_ROT20, cpvm_pkg::ST_ROT22: begin
            mul_a = {{18{cp_ff[15]}}, cp_ff};
            mul_b = (state_ff == cpvm_pkg::ST_ROT20) ? {{2{sy_ff[15]}}, sy_ff}
                                                   : {{2{cy_ff[15]}}, cy_ff};
         end
         cpvm_pkg::ST_DOT: begin
            mul_a = {{2{pos_m[31]}}, pos_m};
            mul_b = {{2{rot_km[15]}}, rot_km};
         end
         default: begin
         end
      endcase

      if (state_ff != cpvm_pkg::ST_IDLE && state_ff != cpvm_pkg::ST_EMIT && !issued_ff) begin
         mul_start = 1'b1;
         issued_in = 1'b1;
      end

      unique case (state_ff)
         cpvm_pkg::ST_IDLE: begin
            if (req_valid) begin
               dx_in = req_mouse_dx;
               dy_in = req_mouse_dy;
               keys_in = req_key_bits;
               sel_in = 2'd0;
               x_in = cpvm_pkg::trig_x(yaw_ff);
               neg_in = yaw_ff[15];
               state_in = req_type ? cpvm_pkg::ST_TRIG_X2 : cpvm_pkg::ST_LOOK_YAW;
            end
         end
         cpvm_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in = k_ff;
               rsp_a_in = row_a;
               rsp_b_in = row_b;
               rsp_c_in = row_c;
               rsp_t_in = trans_ff;
               rsp_last_in = (k_ff == 2'd2);
               k_in = k_ff + 2'd1;
               m_in = 2'd0;
               state_in = (k_ff == 2'd2) ? cpvm_pkg::ST_IDLE : cpvm_pkg::ST_DOT;
            end
         end
         default: begin
            if (issued_ff && mul_done) begin
               issued_in = 1'b0;
               unique case (state_ff)
                  cpvm_pkg::ST_LOOK_YAW: begin
                     yaw_in = yaw_ff + prod[15:0];
                     state_in = cpvm_pkg::ST_LOOK_PITCH;
                  end
                  cpvm_pkg::ST_LOOK_PITCH: begin
                     if (p_wide > 26'sd16384)
                        pitch_in = cpvm_pkg::QUARTER;
                     else if (p_wide < -26'sd16384)
                        pitch_in = -cpvm_pkg::QUARTER;
                     else
                        pitch_in = p_wide[15:0];
                     state_in = cpvm_pkg::ST_IDLE;
                  end
                  cpvm_pkg::ST_TRIG_X2: begin
                     x2_in = prod[32:16];
                     state_in = cpvm_pkg::ST_TRIG_CX;
                  end
                  cpvm_pkg::ST_TRIG_CX: begin
                     t_in = cpvm_pkg::POLY_B - prod[32:16];
                     state_in = cpvm_pkg::ST_TRIG_XT;
                  end
                  cpvm_pkg::ST_TRIG_XT: begin
                     t_in = cpvm_pkg::POLY_A - prod[32:16];
                     state_in = cpvm_pkg::ST_TRIG_S;
                  end
                  cpvm_pkg::ST_TRIG_S: begin
                     case (sel_ff)
                        2'd0: sy_in = s_val;
                        2'd1: cy_in = s_val;
                        2'd2: sp_in = s_val;
                        default: cp_in = s_val;
                     endcase
                     sel_in = sel_ff + 2'd1;
                     x_in = cpvm_pkg::trig_x(next_ang);
                     neg_in = next_ang[15];
                     state_in = (sel_ff == 2'd3) ? cpvm_pkg::ST_MOVE_EX
                                                 : cpvm_pkg::ST_TRIG_X2;
                  end
                  cpvm_pkg::ST_MOVE_EX: begin
                     ex_in = -rnd[17:0];
                     state_in = cpvm_pkg::ST_MOVE_EZ;
                  end
                  cpvm_pkg::ST_MOVE_EZ: begin
                     pos_x_in = cpvm_pkg::sat32(px);
                     pos_y_in = cpvm_pkg::sat32(py);
                     pos_z_in = cpvm_pkg::sat32(pz);
                     state_in = cpvm_pkg::ST_ROT10;
                  end
                  cpvm_pkg::ST_ROT10: begin
                     r10_in = rnd[15:0];
                     state_in = cpvm_pkg::ST_ROT12;
                  end
                  cpvm_pkg::ST_ROT12: begin
                     r12_in = rnd[15:0];
                     state_in = cpvm_pkg::ST_ROT20;
                  end
                  cpvm_pkg::ST_ROT20: begin
                     r20_in = rnd[15:0];
                     state_in = cpvm_pkg::ST_ROT22;
                  end
                  cpvm_pkg::ST_ROT22: begin
                     r22_in = rnd[15:0];
                     k_in = 2'd0;
                     m_in = 2'd0;
                     state_in = cpvm_pkg::ST_DOT;
                  end
                  default: begin
                     acc_in = dot_sum;
                     if (m_ff == 2'd2) begin
                        trans_in = -dot_rnd[33:0];
                        state_in = cpvm_pkg::ST_EMIT;
                     end else begin
                        m_in = m_ff + 2'd1;
                     end
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cpvm_pkg::ST_IDLE;
         move_step_ff <= cpvm_pkg::MOVE_STEP_RESET;
         turn_step_ff <= cpvm_pkg::TURN_STEP_RESET;
         yaw_ff <= '0;
         pitch_ff <= '0;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         pos_z_ff <= '0;
         issued_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         move_step_ff <= move_step_in;
         turn_step_ff <= turn_step_in;
         yaw_ff <= yaw_in;
         pitch_ff <= pitch_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         pos_z_ff <= pos_z_in;
         issued_ff <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      keys_ff <= keys_in;
      x_ff <= x_in;
      x2_ff <= x2_in;
      t_ff <= t_in;
      neg_ff <= neg_in;
      sel_ff <= sel_in;
      sy_ff <= sy_in;
      cy_ff <= cy_in;
      sp_ff <= sp_in;
      cp_ff <= cp_in;
      r10_ff <= r10_in;
      r12_ff <= r12_in;
      r20_ff <= r20_in;
      r22_ff <= r22_in;
      ex_ff <= ex_in;
      acc_ff <= acc_in;
      trans_ff <= trans_in;
      k_ff <= k_in;
      m_ff <= m_in;
      rsp_row_ff <= rsp_row_in;
      rsp_a_ff <= rsp_a_in;
      rsp_b_ff <= rsp_b_in;
      rsp_c_ff <= rsp_c_in;
      rsp_t_ff <= rsp_t_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_row_index = rsp_row_ff;
   assign rsp_rot_a = rsp_a_ff;
   assign rsp_rot_b = rsp_b_ff;
   assign rsp_rot_c = rsp_c_ff;
   assign rsp_trans = rsp_t_ff;
   assign rsp_last_row = rsp_last_ff;

endmodule

FILE: hw/rtl/cpvm_checker.sv
// Port-level checker for the camera pose view matrix unit, bound to the top.
// Depends on camera_pose_view_matrix_unit_assert.svh.
`timescale 1ns / 1ps
`include "camera_pose_view_matrix_unit_assert.svh"

module cpvm_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [1:0]         rsp_row_index,
   input logic signed [15:0] rsp_rot_b,
   input logic               rsp_last_row
);

   `CPVM_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid)
   `CPVM_ASSERT(a_last_flag, rsp_valid |-> (rsp_last_row == (rsp_row_index == 2'd2)))
   `CPVM_ASSERT(a_row_order, rsp_valid && !rsp_stall && !rsp_last_row |=> rsp_valid || req_stall)
   `CPVM_ASSERT(a_row0_zero, rsp_valid && rsp_row_index == 2'd0 |-> rsp_rot_b == 16'sd0)
   `CPVM_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid && !req_stall)

endmodule

bind camera_pose_view_matrix_unit cpvm_checker u_cpvm_checker (.*);

FILE: test/camera_pose_view_matrix_unit_tb.sv
// Self-checking testbench for camera_pose_view_matrix_unit: drives look and frame
// requests, predicts view matrix rows in fixed point and compares every response.
// Depends on cpvm_pkg and the unit RTL.
`timescale 1ns / 1ps

module camera_pose_view_matrix_unit_tb;

   localparam logic REQ_LOOK  = 1'b0;
   localparam logic REQ_FRAME = 1'b1;

   typedef struct packed {
      logic [1:0]         row;
      logic signed [15:0] a;
      logic signed [15:0] b;
      logic signed [15:0] c;
      logic signed [33:0] t;
      logic               last;
   } matrix_row_type;

   typedef struct {
      logic               kind;
      logic signed [11:0] dx;
      logic signed [11:0] dy;
      logic [5:0]         keys;
      bit                 typed;
      matrix_row_type     row0;
   } stim_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_type = 1'b0;
   logic signed [11:0] req_mouse_dx = '0, req_mouse_dy = '0;
   logic [5:0] req_key_bits = '0;
   logic req_stall, rsp_valid, rsp_last_row, csr_ready;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_row_index;
   logic signed [15:0] rsp_rot_a, rsp_rot_b, rsp_rot_c;
   logic signed [33:0] rsp_trans;
   logic csr_valid = 1'b0;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   camera_pose_view_matrix_unit uut (.*);

   always #10 clock = ~clock;

   logic [15:0] step_move;
   logic [11:0] step_turn;
   logic [15:0] yaw;
   longint pitch;
   longint px, py, pz;
   matrix_row_type rows_due[$];
   int mismatches = 0;
   int send_idle = 0, recv_idle = 0;

   function automatic longint rnd_half_up(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint sine_q14(logic [15:0] ang);
      logic [1:0] quad;
      longint r, x, x2, t, s;
      quad = ang[15:14];
      r = ang[13:0];
      if (quad[0]) r = 16384 - r;
      x = r << 2;
      x2 = (x * x) >> 16;
      t = 42048 - ((4640 * x2) >> 16);
      t = 102944 - ((x2 * t) >> 16);
      s = (x * t) >> 16;
      s = ((s << 14) + 32768) >> 16;
      if (s > 16384) s = 16384;
      return quad[1] ? -s : s;
   endfunction

   function automatic longint cosine_q14(logic [15:0] ang);
      return sine_q14(ang + 16'd16384);
   endfunction

   task automatic predict_request(logic kind, logic signed [11:0] dx,
                                  logic signed [11:0] dy, logic [5:0] k);
      longint f, l, u, ex, ez, sy, cy, sp, cp, d;
      longint m[3][3];
      matrix_row_type r;
      if (kind == REQ_LOOK) begin
         yaw = yaw + 16'(longint'(step_turn) * longint'(dx));
         pitch = pitch + longint'(step_turn) * longint'(dy);
         if (pitch > 16384) pitch = 16384;
         if (pitch < -16384) pitch = -16384;
         return;
      end
      f = longint'(k[0]) - longint'(k[1]);
      l = longint'(k[2]) - longint'(k[3]);
      u = longint'(k[4]) - longint'(k[5]);
      ex = -rnd_half_up(longint'(step_move) * sine_q14(yaw), 14);
      ez = -rnd_half_up(longint'(step_move) * cosine_q14(yaw), 14);
      px = clamp32(px + f * ex + l * ez);
      pz = clamp32(pz + f * ez - l * ex);
      py = clamp32(py + u * longint'(step_move));
      sy = sine_q14(yaw);
      cy = cosine_q14(yaw);
      sp = sine_q14(16'(pitch));
      cp = cosine_q14(16'(pitch));
      m[0][0] = cy; m[0][1] = 0; m[0][2] = -sy;
      m[1][0] = rnd_half_up(sp * sy, 14); m[1][1] = cp; m[1][2] = rnd_half_up(sp * cy, 14);
      m[2][0] = rnd_half_up(cp * sy, 14); m[2][1] = -sp; m[2][2] = rnd_half_up(cp * cy, 14);
      for (int i = 0; i < 3; i++) begin
         d = m[i][0] * px + m[i][1] * py + m[i][2] * pz;
         r.row = 2'(i);
         r.a = 16'(m[i][0]);
         r.b = 16'(m[i][1]);
         r.c = 16'(m[i][2]);
         r.t = 34'(-rnd_half_up(d, 14));
         r.last = (i == 2);
         rows_due.push_back(r);
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   always @(posedge clock) begin
      matrix_row_type e, got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_row_index, rsp_rot_a, rsp_rot_b, rsp_rot_c, rsp_trans, rsp_last_row};
         if (rows_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected row %p", got);
         end else begin
            e = rows_due.pop_front();
            if (got !== e) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch exp %p got %p", e, got);
            end
         end
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == cpvm_pkg::CSR_IDX_MOVE) step_move = val;
      else step_turn = val[11:0];
      @(posedge clock);
   endtask

   task automatic drain();
      while (rows_due.size() != 0) @(posedge clock);
      repeat (800) @(posedge clock);
   endtask

   task automatic send_request(logic kind, logic signed [11:0] dx,
                               logic signed [11:0] dy, logic [5:0] k);
      while ($urandom_range(99) < send_idle) @(posedge clock);
      req_valid <= 1'b1;
      req_type <= kind;
      req_mouse_dx <= dx;
      req_mouse_dy <= dy;
      req_key_bits <= k;
      do @(posedge clock); while (req_stall);
      predict_request(kind, dx, dy, k);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   stim_type plan[$];

   task automatic add_step(logic kind, int dx, int dy, int k);
      stim_type s;
      s.kind = kind; s.dx = 12'(dx); s.dy = 12'(dy); s.keys = 6'(k);
      s.typed = 1'b0; s.row0 = '0;
      plan.push_back(s);
   endtask

   task automatic random_requests(int n);
      logic kind;
      for (int i = 0; i < n; i++) begin
         kind = ($urandom_range(99) < 55) ? REQ_FRAME : REQ_LOOK;
         send_request(kind, 12'($urandom), 12'($urandom), 6'($urandom));
      end
   endtask

   initial begin
      stim_type s;
      step_move = cpvm_pkg::MOVE_STEP_RESET;
      step_turn = cpvm_pkg::TURN_STEP_RESET;
      yaw = '0; pitch = 0; px = 0; py = 0; pz = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset: identity rotation, zero translation
      s.kind = REQ_FRAME; s.dx = '0; s.dy = '0; s.keys = '0; s.typed = 1'b1;
      s.row0 = '{2'd0, 16'sd16384, 16'sd0, 16'sd0, 34'sd0, 1'b0};
      plan.push_back(s);
      add_step(REQ_FRAME, 0, 0, 6'h01);
      add_step(REQ_FRAME, 0, 0, 6'h03);
      add_step(REQ_FRAME, 0, 0, 6'h0c);
      add_step(REQ_FRAME, 0, 0, 6'h30);
      add_step(REQ_FRAME, 0, 0, 6'h3f);
      add_step(REQ_FRAME, 0, 0, 6'h15);
      add_step(REQ_FRAME, 0, 0, 6'h2a);
      add_step(REQ_LOOK, 2047, 2047, 6'h3f);
      add_step(REQ_FRAME, -2048, -2048, 6'h05);
      add_step(REQ_LOOK, -2048, -2048, 0);
      add_step(REQ_FRAME, 0, 0, 6'h0a);
      add_step(REQ_LOOK, 256, 0, 0);
      add_step(REQ_FRAME, 0, 0, 6'h01);
      add_step(REQ_LOOK, 512, 128, 0);
      add_step(REQ_FRAME, 0, 0, 6'h09);
      foreach (plan[i]) begin
         send_request(plan[i].kind, plan[i].dx, plan[i].dy, plan[i].keys);
         if (plan[i].typed && rows_due.size() != 0 && rows_due[0] !== plan[i].row0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("typed row0 mismatch exp %p pred %p", plan[i].row0, rows_due[0]);
         end
      end
      drain();

      // full step sizes drive pitch clamp
      write_reg(cpvm_pkg::CSR_IDX_MOVE, 16'hffff);
      write_reg(cpvm_pkg::CSR_IDX_TURN, 16'h0fff);
      send_idle = 16; recv_idle = 81;
      random_requests(40);
      drain();
      write_reg(cpvm_pkg::CSR_IDX_MOVE, 16'h0000);
      write_reg(cpvm_pkg::CSR_IDX_TURN, 16'h0000);
      send_idle = 81; recv_idle = 16;
      random_requests(20);
      drain();
      write_reg(cpvm_pkg::CSR_IDX_MOVE, 16'($urandom));
      write_reg(cpvm_pkg::CSR_IDX_TURN, 16'($urandom_range(4095)));
      send_idle = 0; recv_idle = 0;
      random_requests(60);
      drain();

      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #200ms;
      $display("Test completed with failures");
      $finish;
   end
endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/cpvm_pkg.sv
hw/rtl/cpvm_serial_mul.sv
hw/rtl/camera_pose_view_matrix_unit.sv
hw/rtl/cpvm_checker.sv
test/camera_pose_view_matrix_unit_tb.sv
